// ===== rtl/dcq_pkg.sv =====
// Shared types and constants for the delayed command queue.
// No dependencies; imported by every module of the block.
package dcq_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCC_W       = 6;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned WELL_W      = 8;
  localparam int unsigned DELAY_W     = 32;

  // item opcodes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  localparam logic REG_ON_CODE  = 1'b0;
  localparam logic REG_OFF_CODE = 1'b1;

  localparam logic [CODE_W-1:0] ON_CODE_RST  = 8'd1;
  localparam logic [CODE_W-1:0] OFF_CODE_RST = 8'd2;

  // result kinds
  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_FIRED    = 2'd1;
  localparam logic [1:0] KIND_TICK_END = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic [CODE_W-1:0]  command_code;
    logic [WELL_W-1:0]  well_number;
    logic [DELAY_W-1:0] delay_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic              accepted;
    logic [WELL_W-1:0] fired_well;
    logic [OCC_W-1:0]  occupancy;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               is_on;
    logic [WELL_W-1:0]  well;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_POP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic add_en;
    logic tick_init;
    logic walk_en;
    logic walk_commit;
    logic pop_en;
    logic emit_end;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
    logic pop_done;
  } dp_stat_t;

endpackage

// ===== rtl/dcq_ctrl.sv =====
// Sequencer for the delayed command queue: idle / walk / pop.
// Depends on dcq_pkg.
module dcq_ctrl
  import dcq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     item_cmd_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (item_cmd_i == CMD_ADD) begin
            cmd_o.add_en = 1'b1;
          end else begin
            cmd_o.tick_init = 1'b1;
            state_d         = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd_o.walk_en = 1'b1;
        if (stat_i.walk_done) begin
          cmd_o.walk_commit = 1'b1;
          state_d           = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o.pop_en = 1'b1;
        if (stat_i.pop_done) begin
          cmd_o.emit_end = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dcq_datapath.sv =====
// Entry list, fired-well stack, config registers and result register.
// Depends on dcq_pkg; sequenced by dcq_ctrl.
module dcq_datapath
  import dcq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CODE_W-1:0] cfg_data_i,
  input  in_item_t          item_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  output logic              result_valid_o,
  output out_item_t         result_o
);

  entry_t            entry_mem [QUEUE_DEPTH];
  logic [WELL_W-1:0] stack_mem [QUEUE_DEPTH];

  logic [CODE_W-1:0] on_code_q, off_code_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]  sp_q, sp_d;
  logic              pend_q, pend_d;
  logic              popv_q, popv_d;
  logic              res_valid_q, res_valid_d;
  out_item_t         res_q, res_d;
  entry_t            ent_rdata_q;
  logic [WELL_W-1:0] stk_rdata_q;

  logic              code_on, code_known, add_ok;
  logic              rd_go, proc, fire, push, keep, pop_rd;
  logic              ent_we;
  logic [IDX_W-1:0]  ent_waddr;
  entry_t            ent_wdata;
  logic [CNT_W-1:0]  sp_dec, count_inc;

  // equal codes count as turn-on
  assign code_on    = item_i.command_code == on_code_q;
  assign code_known = code_on || (item_i.command_code == off_code_q);
  assign add_ok     = code_known && (count_q < CNT_W'(QUEUE_DEPTH));
  assign count_inc  = count_q + CNT_W'(1);

  assign rd_go  = cmd_i.walk_en && (rd_idx_q != count_q);
  assign proc   = cmd_i.walk_en && pend_q;
  assign fire   = (ent_rdata_q.delay == '0) && ent_rdata_q.is_on;
  assign push   = proc && fire;
  assign keep   = proc && !fire;
  assign pop_rd = cmd_i.pop_en && (sp_q != '0);
  assign sp_dec = sp_q - CNT_W'(1);

  assign stat_o.walk_done = (rd_idx_q == count_q) && !pend_q;
  assign stat_o.pop_done  = (sp_q == '0) && !popv_q;

  // entry write port: append on add, compacting write-back during the walk
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = wr_idx_q[IDX_W-1:0];
    ent_wdata = ent_rdata_q;
    if (cmd_i.add_en && add_ok) begin
      ent_we          = 1'b1;
      ent_waddr       = count_q[IDX_W-1:0];
      ent_wdata.delay = item_i.delay_seconds;
      ent_wdata.is_on = code_on;
      ent_wdata.well  = item_i.well_number;
    end else if (keep) begin
      ent_we = 1'b1;
      if (ent_rdata_q.delay != '0) begin
        ent_wdata.delay = ent_rdata_q.delay - DELAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      ent_rdata_q <= entry_mem[rd_idx_q[IDX_W-1:0]];
    end
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
  end

  // fired wells pushed in ascending index order, popped highest first
  always_ff @(posedge clk_i) begin
    if (pop_rd) begin
      stk_rdata_q <= stack_mem[sp_dec[IDX_W-1:0]];
    end
    if (push) begin
      stack_mem[sp_q[IDX_W-1:0]] <= ent_rdata_q.well;
    end
  end

  always_comb begin
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    sp_d        = sp_q;
    pend_d      = pend_q;
    popv_d      = popv_q;
    res_valid_d = 1'b0;
    res_d       = '0;

    if (cmd_i.add_en) begin
      res_valid_d       = 1'b1;
      res_d.result_kind = KIND_ADD;
      res_d.accepted    = add_ok;
      res_d.last        = 1'b1;
      if (add_ok) begin
        count_d = count_inc;
      end
      res_d.occupancy = OCC_W'(count_d);
    end

    if (cmd_i.tick_init) begin
      rd_idx_d = '0;
      wr_idx_d = '0;
      sp_d     = '0;
      pend_d   = 1'b0;
      popv_d   = 1'b0;
    end

    if (cmd_i.walk_en) begin
      pend_d = rd_go;
      if (rd_go) begin
        rd_idx_d = rd_idx_q + CNT_W'(1);
      end
      if (keep) begin
        wr_idx_d = wr_idx_q + CNT_W'(1);
      end
      if (push) begin
        sp_d = sp_q + CNT_W'(1);
      end
    end

    if (cmd_i.walk_commit) begin
      count_d = wr_idx_q;
    end

    if (cmd_i.pop_en) begin
      popv_d = pop_rd;
      if (pop_rd) begin
        sp_d = sp_dec;
      end
      if (popv_q) begin
        res_valid_d       = 1'b1;
        res_d.result_kind = KIND_FIRED;
        res_d.fired_well  = stk_rdata_q;
        res_d.occupancy   = OCC_W'(count_q);
      end
    end

    if (cmd_i.emit_end) begin
      res_valid_d       = 1'b1;
      res_d.result_kind = KIND_TICK_END;
      res_d.occupancy   = OCC_W'(count_q);
      res_d.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_code_q   <= ON_CODE_RST;
      off_code_q  <= OFF_CODE_RST;
      count_q     <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      sp_q        <= '0;
      pend_q      <= 1'b0;
      popv_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ON_CODE:  on_code_q  <= cfg_data_i;
          REG_OFF_CODE: off_code_q <= cfg_data_i;
          default: ;
        endcase
      end
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      sp_q        <= sp_d;
      pend_q      <= pend_d;
      popv_q      <= popv_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== rtl/delayed_command_queue_top.sv =====
// Channel    | Handshake              | Payload
// -----------+------------------------+----------------------------------
// command    | start, busy            | item_i   (in_item_t)
// result     | result_valid_o strobe  | result_o (out_item_t)
// config     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// Add: busy stays low; the reply shows the cycle after.
// Tick: the walk makes one registered entry RAM read per held entry, then the
// pop phase makes one stack read per result.
// Reset clears the controller and entry count and loads the config registers
// with their reset codes; no RAM clearing pass. Results are one-cycle
// strobes; the receiver cannot stall.
// Top level of the delayed command queue; depends on dcq_pkg, dcq_ctrl and
// dcq_datapath.
module delayed_command_queue_top
  import dcq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  in_item_t          item_i,
  output logic              result_valid_o,
  output out_item_t         result_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CODE_W-1:0] cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  dcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .item_cmd_i (item_i.cmd),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd),
    .busy       (busy)
  );

  dcq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
